[sv/utce_pkg.sv]
// ----------------------------------------------------------------------------
// utce_pkg: shared types and constants for the UTF-8 text cursor engine
// Word formats of the text and draw channels, register indexes and
// the control codes that move the pen.
// ----------------------------------------------------------------------------
`default_nettype none

package utce_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_ORIGIN_X      = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y      = 3'd1;
  localparam logic [2:0] REG_GLYPH_WIDTH   = 3'd2;
  localparam logic [2:0] REG_GLYPH_HEIGHT  = 3'd3;
  localparam logic [2:0] REG_GLYPH_COUNT   = 3'd4;
  localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd5;
  localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd6;
  localparam logic [2:0] REG_PEN_COLOR     = 3'd7;

  // Register reset values
  localparam logic [15:0] RST_ORIGIN_X      = 16'd0;
  localparam logic [15:0] RST_ORIGIN_Y      = 16'd0;
  localparam logic [5:0]  RST_GLYPH_WIDTH   = 6'd8;
  localparam logic [6:0]  RST_GLYPH_HEIGHT  = 7'd16;
  localparam logic [15:0] RST_GLYPH_COUNT   = 16'd256;
  localparam logic [15:0] RST_SCREEN_WIDTH  = 16'd1024;
  localparam logic [15:0] RST_SCREEN_HEIGHT = 16'd768;
  localparam logic [31:0] RST_PEN_COLOR     = 32'h00FF_FFFF;

  // Control codes
  localparam logic [20:0] CODE_TAB = 21'd9;
  localparam logic [20:0] CODE_LF  = 21'd10;
  localparam logic [20:0] CODE_CR  = 21'd13;

  // Substitute glyph ('?') and stray-byte prefix
  localparam logic [20:0] GLYPH_SUBST  = 21'd63;
  localparam logic [12:0] STRAY_PREFIX = 13'h1FFF;

  // Lead byte masks and tags
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_TAG  = 8'hF0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_TAG  = 8'hE0;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_TAG  = 8'hC0;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       string_start;
  } text_word_t;

  typedef struct packed {
    logic [15:0] draw_x;
    logic [15:0] draw_y;
    logic [20:0] glyph_index;
    logic [31:0] draw_color;
  } draw_word_t;

endpackage

`default_nettype wire

[sv/utf8_text_cursor_engine.sv]
// A text word taken into the input register passes the decode/cursor logic
//   into the output register, which gives its draw word on out_valid_o.
//   Throughput: one text word per cycle unless a drawing word meets a held
//   output; the cursor update loop (decode, saturating add, compare) sets it.
// Reset: rst_ni clears the pipeline, restores register defaults and puts the
//   cursor at the default origin.
// ----------------------------------------------------------------------------
// utf8_text_cursor_engine: UTF-8 decoder with pen cursor
// Decodes a byte stream by lead byte, tracks x/y/tab phase, and emits one
// draw word per code other than tab, LF and CR that lands on screen.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_text_cursor_engine
  import utce_pkg::*;
#(
  parameter int TAB_GLYPHS = 4,
  parameter int COORD_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // text channel
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire text_word_t  in_data_i,
  // draw channel
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output draw_word_t       out_data_o,
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  localparam int CW      = COORD_BITS;
  localparam int CMP_W   = (CW > 16) ? CW : 16;
  localparam int PHASE_W = (TAB_GLYPHS > 1) ? $clog2(TAB_GLYPHS) : 1;

  // Configuration registers
  logic [15:0] origin_x_q, origin_y_q, glyph_count_q;
  logic [15:0] screen_width_q, screen_height_q;
  logic [5:0]  glyph_width_q;
  logic [6:0]  glyph_height_q;
  logic [31:0] pen_color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q      <= RST_ORIGIN_X;
      origin_y_q      <= RST_ORIGIN_Y;
      glyph_width_q   <= RST_GLYPH_WIDTH;
      glyph_height_q  <= RST_GLYPH_HEIGHT;
      glyph_count_q   <= RST_GLYPH_COUNT;
      screen_width_q  <= RST_SCREEN_WIDTH;
      screen_height_q <= RST_SCREEN_HEIGHT;
      pen_color_q     <= RST_PEN_COLOR;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_ORIGIN_X:      origin_x_q      <= cfg_data_i[15:0];
        REG_ORIGIN_Y:      origin_y_q      <= cfg_data_i[15:0];
        REG_GLYPH_WIDTH:   glyph_width_q   <= cfg_data_i[5:0];
        REG_GLYPH_HEIGHT:  glyph_height_q  <= cfg_data_i[6:0];
        REG_GLYPH_COUNT:   glyph_count_q   <= cfg_data_i[15:0];
        REG_SCREEN_WIDTH:  screen_width_q  <= cfg_data_i[15:0];
        REG_SCREEN_HEIGHT: screen_height_q <= cfg_data_i[15:0];
        REG_PEN_COLOR:     pen_color_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Origin masked to the cursor width
  logic [CMP_W-1:0] org_x_ext, org_y_ext;
  logic [CW-1:0]    org_x, org_y;
  assign org_x_ext = CMP_W'(origin_x_q);
  assign org_y_ext = CMP_W'(origin_y_q);
  assign org_x     = org_x_ext[CW-1:0];
  assign org_y     = org_y_ext[CW-1:0];

  // Input register
  logic       s1_valid_q;
  text_word_t s1_data_q;
  logic       s1_go;
  logic       out_free;
  logic       draw;

  assign out_free   = !out_valid_o || out_ready_i;
  assign s1_go      = s1_valid_q && (!draw || out_free);
  assign in_ready_o = !s1_valid_q || s1_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_data_q <= in_data_i;
    end
  end

  // Decoder and cursor state
  logic [CW-1:0]      cursor_x_q, cursor_y_q;
  logic [PHASE_W-1:0] tab_phase_q;
  logic [20:0]        code_accum_q;
  logic [1:0]         bytes_pending_q;

  logic [CW-1:0]      cx, cy, cx_d, cy_d;
  logic [PHASE_W-1:0] ph, ph_d;
  logic [20:0]        acc, acc_d;
  logic [1:0]         pend, pend_d;
  logic               code_vld;
  logic [20:0]        code;
  logic [7:0]         b;

  // Byte decode, after any string-start reset
  always_comb begin
    b        = s1_data_q.text_byte;
    cx       = s1_data_q.string_start ? org_x : cursor_x_q;
    cy       = s1_data_q.string_start ? org_y : cursor_y_q;
    ph       = s1_data_q.string_start ? '0 : tab_phase_q;
    acc      = s1_data_q.string_start ? '0 : code_accum_q;
    pend     = s1_data_q.string_start ? '0 : bytes_pending_q;
    code_vld = 1'b0;
    code     = acc;
    acc_d    = acc;
    pend_d   = pend;
    if (b == 8'd0) begin
      acc_d  = '0;
      pend_d = '0;
    end else if (pend != 2'd0) begin
      acc_d    = {acc[14:0], b[5:0]};
      pend_d   = pend - 2'd1;
      code     = acc_d;
      code_vld = (pend_d == 2'd0);
    end else if ((b & LEAD4_MASK) == LEAD4_TAG) begin
      acc_d  = 21'(b[2:0]);
      pend_d = 2'd3;
    end else if ((b & LEAD3_MASK) == LEAD3_TAG) begin
      acc_d  = 21'(b[3:0]);
      pend_d = 2'd2;
    end else if ((b & LEAD2_MASK) == LEAD2_TAG) begin
      acc_d  = 21'(b[4:0]);
      pend_d = 2'd1;
    end else begin
      code     = b[7] ? {STRAY_PREFIX, b} : 21'(b);
      acc_d    = code;
      code_vld = 1'b1;
    end
  end

  // Code handling: cursor moves and the draw decision
  logic              is_lf, is_cr, is_tab, is_glyph;
  logic [4:0]        tab_cols;
  logic [10:0]       adv_x;
  logic [CW:0]       sum_x, sum_y;
  logic [CW-1:0]     sat_x, sat_y;
  logic [CMP_W-1:0]  cx_ext, cy_ext;
  logic [20:0]       glyph;

  assign is_lf    = code_vld && (code == CODE_LF);
  assign is_cr    = code_vld && (code == CODE_CR);
  assign is_tab   = code_vld && (code == CODE_TAB);
  assign is_glyph = code_vld && !is_lf && !is_cr && !is_tab;

  assign tab_cols = 5'(TAB_GLYPHS) - 5'(ph);
  assign adv_x    = is_tab ? (11'(glyph_width_q) * 11'(tab_cols)) : 11'(glyph_width_q);
  assign sum_x    = {1'b0, cx} + (CW+1)'(adv_x);
  assign sum_y    = {1'b0, cy} + (CW+1)'(glyph_height_q);
  assign sat_x    = sum_x[CW] ? '1 : sum_x[CW-1:0];
  assign sat_y    = sum_y[CW] ? '1 : sum_y[CW-1:0];

  assign cx_ext = CMP_W'(cx);
  assign cy_ext = CMP_W'(cy);
  assign draw   = is_glyph && (cx_ext < CMP_W'(screen_width_q))
                           && (cy_ext < CMP_W'(screen_height_q));
  assign glyph  = (code >= 21'(glyph_count_q)) ? GLYPH_SUBST : code;

  always_comb begin
    cx_d = cx;
    cy_d = cy;
    ph_d = ph;
    if (is_lf) begin
      cy_d = sat_y;
      cx_d = org_x;
      ph_d = '0;
    end else if (is_cr) begin
      cx_d = org_x;
      ph_d = '0;
    end else if (is_tab) begin
      cx_d = sat_x;
      ph_d = '0;
    end else if (is_glyph) begin
      cx_d = sat_x;
      ph_d = (ph == PHASE_W'(TAB_GLYPHS - 1)) ? '0 : ph + PHASE_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_x_q      <= '0;
      cursor_y_q      <= '0;
      tab_phase_q     <= '0;
      code_accum_q    <= '0;
      bytes_pending_q <= '0;
    end else if (s1_go) begin
      cursor_x_q      <= cx_d;
      cursor_y_q      <= cy_d;
      tab_phase_q     <= ph_d;
      code_accum_q    <= acc_d;
      bytes_pending_q <= pend_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (s1_go && draw) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && draw) begin
      out_data_o.draw_x      <= cx_ext[15:0];
      out_data_o.draw_y      <= cy_ext[15:0];
      out_data_o.glyph_index <= glyph;
      out_data_o.draw_color  <= pen_color_q;
    end
  end

  // Assertions
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(tab_phase_q) < TAB_GLYPHS)
    else $error("tab phase out of range");

  a_zero_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_go && s1_data_q.text_byte == 8'd0) |=> (bytes_pending_q == 2'd0))
    else $error("zero byte left a partial sequence");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output register");

endmodule

`default_nettype wire

[verif/utf8_text_cursor_engine_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_text_cursor_engine_tb: self-checking bench for the UTF-8 text cursor
// Drives text words through the valid/ready channel and mirrors the decode
// and pen cursor behavior in a local draw predictor. Each draw word is
// compared field by field with the oldest prediction. Directed tests cover
// lead bytes, stray bytes, overlong forms, control codes, string breaks and
// register extremes. Random tests run the block under varying font and screen
// settings and idle/stall mixes. One test holds the draw channel off for a
// long stretch.
// ----------------------------------------------------------------------------

module utf8_text_cursor_engine_tb;
  import utce_pkg::*;

  localparam int          TAB_STOP       = 4;
  localparam int unsigned COORD_MAX      = 65535;
  localparam int          SETTLE_CYCLES  = 8;
  localparam int          HOLD_CYCLES    = 400;
  localparam int          WATCHDOG_LIMIT = 3000;
  localparam int          REPORT_CAP     = 40;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  text_word_t  in_data_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  draw_word_t  out_data_o;
  logic        cfg_we_i    = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i  = '0;

  // Register shadows used by the draw predictor
  int unsigned org_x, org_y, adv_w, adv_h, font_glyphs, scr_w, scr_h;
  logic [31:0] ink;

  // Pen and decoder state of the predictor
  int unsigned pen_x, pen_y;
  int unsigned tab_col;
  logic [20:0] seq_code;
  int unsigned seq_left;

  draw_word_t  draws_due[$];
  int unsigned mismatches       = 0;
  int unsigned text_words_sent  = 0;
  int unsigned send_idle_pct    = 0;
  int unsigned ready_stall_pct  = 0;
  bit          hold_req         = 1'b0;

  utf8_text_cursor_engine DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Draw predictor
  // ---------------------------------------------------------------------------
  function automatic int unsigned coord_sat(input int unsigned sum);
    return (sum > COORD_MAX) ? COORD_MAX : sum;
  endfunction

  function automatic void pen_home();
    pen_x   = org_x;
    pen_y   = org_y;
    tab_col = 0;
  endfunction

  function automatic void reset_predictor();
    org_x       = 32'(RST_ORIGIN_X);
    org_y       = 32'(RST_ORIGIN_Y);
    adv_w       = 32'(RST_GLYPH_WIDTH);
    adv_h       = 32'(RST_GLYPH_HEIGHT);
    font_glyphs = 32'(RST_GLYPH_COUNT);
    scr_w       = 32'(RST_SCREEN_WIDTH);
    scr_h       = 32'(RST_SCREEN_HEIGHT);
    ink         = RST_PEN_COLOR;
    pen_home();
    seq_code = '0;
    seq_left = 0;
  endfunction

  // Moves the pen for one decoded code; returns 1 when a draw word results
  function automatic bit apply_code(input logic [20:0] code, output draw_word_t d);
    bit hit;
    hit = 1'b0;
    d   = '0;
    if (code == CODE_LF) begin
      pen_y   = coord_sat(pen_y + adv_h);
      pen_x   = org_x;
      tab_col = 0;
    end else if (code == CODE_CR) begin
      pen_x   = org_x;
      tab_col = 0;
    end else if (code == CODE_TAB) begin
      pen_x   = coord_sat(pen_x + adv_w * (TAB_STOP - tab_col));
      tab_col = 0;
    end else begin
      if (pen_x < scr_w && pen_y < scr_h) begin
        d.draw_x      = 16'(pen_x);
        d.draw_y      = 16'(pen_y);
        d.glyph_index = (32'(code) >= font_glyphs) ? GLYPH_SUBST : code;
        d.draw_color  = ink;
        hit = 1'b1;
      end
      pen_x   = coord_sat(pen_x + adv_w);
      tab_col = (tab_col + 1) % TAB_STOP;
    end
    return hit;
  endfunction

  function automatic bit predict_draw(input text_word_t w, output draw_word_t d);
    logic [7:0] b;
    b = w.text_byte;
    d = '0;
    if (w.string_start) begin
      pen_home();
      seq_left = 0;
      seq_code = '0;
    end
    if (b == 8'h00) begin
      seq_left = 0;
      seq_code = '0;
      return 1'b0;
    end
    // continuation: tag bits are ignored
    if (seq_left != 0) begin
      seq_code = {seq_code[14:0], b[5:0]};
      seq_left--;
      if (seq_left != 0) return 1'b0;
      return apply_code(seq_code, d);
    end
    if ((b & LEAD4_MASK) == LEAD4_TAG) begin
      seq_code = 21'(b[2:0]);
      seq_left = 3;
      return 1'b0;
    end
    if ((b & LEAD3_MASK) == LEAD3_TAG) begin
      seq_code = 21'(b[3:0]);
      seq_left = 2;
      return 1'b0;
    end
    if ((b & LEAD2_MASK) == LEAD2_TAG) begin
      seq_code = 21'(b[4:0]);
      seq_left = 1;
      return 1'b0;
    end
    // stray high bytes get a code far past any glyph count
    if (b[7]) seq_code = {STRAY_PREFIX, b};
    else      seq_code = 21'(b);
    return apply_code(seq_code, d);
  endfunction

  // ---------------------------------------------------------------------------
  // Mismatch reporting and draw checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what);
    if (mismatches < REPORT_CAP) $display("ERROR @%0t: %s", $time, what);
    mismatches++;
  endtask

  task automatic check_draw(input draw_word_t got);
    draw_word_t want;
    if (draws_due.size() == 0) begin
      report_mismatch($sformatf("draw word x=%0d y=%0d glyph=%0d with none expected",
                                got.draw_x, got.draw_y, got.glyph_index));
    end else begin
      want = draws_due.pop_front();
      if (got.draw_x !== want.draw_x)
        report_mismatch($sformatf("draw_x %0d, expected %0d", got.draw_x, want.draw_x));
      if (got.draw_y !== want.draw_y)
        report_mismatch($sformatf("draw_y %0d, expected %0d", got.draw_y, want.draw_y));
      if (got.glyph_index !== want.glyph_index)
        report_mismatch($sformatf("glyph_index %0d, expected %0d",
                                  got.glyph_index, want.glyph_index));
      if (got.draw_color !== want.draw_color)
        report_mismatch($sformatf("draw_color %h, expected %h",
                                  got.draw_color, want.draw_color));
    end
  endtask

  // Draw channel is sampled mid-cycle, where it is stable
  initial begin
    forever begin
      @(negedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) check_draw(out_data_o);
    end
  end

  // Draw channel ready: random stalls, or a long hold-off on request
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= ready_stall_pct);
      end
    end
  end

  // Watchdog: ends the run after too many cycles with no word moving
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(negedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Drivers (called in the time step of a rising edge)
  // ---------------------------------------------------------------------------
  task automatic put_text(input logic [7:0] b, input logic ss = 1'b0);
    text_word_t w;
    draw_word_t d;
    bit         taken;
    w.text_byte    = b;
    w.string_start = ss;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end while (!taken);
    text_words_sent++;
    if (predict_draw(w, d)) draws_due.push_back(d);
  endtask

  // Stops offering text and waits until every draw word is in and checked
  task automatic drain_draws();
    in_valid_i <= 1'b0;
    while (draws_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_ORIGIN_X:      org_x       = 32'(val[15:0]);
      REG_ORIGIN_Y:      org_y       = 32'(val[15:0]);
      REG_GLYPH_WIDTH:   adv_w       = 32'(val[5:0]);
      REG_GLYPH_HEIGHT:  adv_h       = 32'(val[6:0]);
      REG_GLYPH_COUNT:   font_glyphs = 32'(val[15:0]);
      REG_SCREEN_WIDTH:  scr_w       = 32'(val[15:0]);
      REG_SCREEN_HEIGHT: scr_h       = 32'(val[15:0]);
      REG_PEN_COLOR:     ink         = val;
      default: ;
    endcase
  endtask

  function automatic logic [7:0] cont_byte();
    // now and then a random byte, whose tag need not be 10
    if ($urandom_range(9) == 0) return 8'($urandom_range(1, 255));
    return {2'b10, 6'($urandom)};
  endfunction

  // One random character: mostly well-formed UTF-8, some noise and breaks
  task automatic send_random_char();
    int unsigned kind;
    logic        ss;
    kind = $urandom_range(99);
    ss   = ($urandom_range(24) == 0);
    if (kind < 40) begin
      put_text(8'($urandom_range(32, 126)), ss);
    end else if (kind < 48) begin
      case ($urandom_range(2))
        0:       put_text(8'(CODE_TAB), ss);
        1:       put_text(8'(CODE_LF), ss);
        default: put_text(8'(CODE_CR), ss);
      endcase
    end else if (kind < 62) begin
      put_text({3'b110, 5'($urandom)}, ss);
      put_text(cont_byte());
    end else if (kind < 72) begin
      put_text({4'b1110, 4'($urandom)}, ss);
      put_text(cont_byte());
      put_text(cont_byte());
    end else if (kind < 78) begin
      put_text({5'b11110, 3'($urandom)}, ss);
      put_text(cont_byte());
      put_text(cont_byte());
      put_text(cont_byte());
    end else if (kind < 86) begin
      put_text(8'($urandom), ss);
    end else if (kind < 92) begin
      // sequence cut short by a zero byte or a new string
      put_text({4'b1110, 4'($urandom)}, ss);
      put_text(cont_byte());
      if ($urandom_range(1) == 0) put_text(8'h00);
      else                        put_text(8'($urandom_range(32, 126)), 1'b1);
    end else if (kind < 96) begin
      put_text(8'h00, ss);
    end else begin
      // overlong two-byte form of a control code or of zero
      put_text(8'hC0, ss);
      case ($urandom_range(3))
        0:       put_text(8'h80 | 8'(CODE_TAB));
        1:       put_text(8'h80 | 8'(CODE_LF));
        2:       put_text(8'h80 | 8'(CODE_CR));
        default: put_text(8'h80);
      endcase
    end
  endtask

  task automatic setup_random_font();
    write_reg(REG_ORIGIN_X, ($urandom_range(7) == 0) ? $urandom_range(0, 65535)
                                                     : $urandom_range(0, 300));
    write_reg(REG_ORIGIN_Y, ($urandom_range(7) == 0) ? $urandom_range(0, 65535)
                                                     : $urandom_range(0, 200));
    write_reg(REG_GLYPH_WIDTH, $urandom_range(1, 32));
    write_reg(REG_GLYPH_HEIGHT, $urandom_range(1, 64));
    case ($urandom_range(3))
      0:       write_reg(REG_GLYPH_COUNT, $urandom_range(1, 65535));
      1:       write_reg(REG_GLYPH_COUNT, $urandom_range(64, 200));
      2:       write_reg(REG_GLYPH_COUNT, 65535);
      default: write_reg(REG_GLYPH_COUNT, 256);
    endcase
    write_reg(REG_SCREEN_WIDTH, $urandom_range(200, 1920));
    write_reg(REG_SCREEN_HEIGHT, $urandom_range(100, 1080));
    write_reg(REG_PEN_COLOR, $urandom);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Lead bytes, stray bytes, overlong zero, unchecked tags, reset settings
  task automatic test_default_decode();
    put_text("A", 1'b1);
    put_text(8'h7F);
    put_text(8'hC3); put_text(8'hA9);
    put_text(8'hE2); put_text(8'h82); put_text(8'hAC);
    put_text(8'hF4); put_text(8'h8F); put_text(8'hBF); put_text(8'hBF);
    put_text(8'h80);
    put_text(8'hFF);
    put_text(8'hF8);
    put_text(8'hC0); put_text(8'h80);
    put_text(8'hC3); put_text(8'h41);
    drain_draws();
  endtask

  // Tab phase, newline, carriage return and the overlong control forms
  task automatic test_cursor_controls();
    put_text("a", 1'b1);
    put_text(8'(CODE_TAB));
    put_text("b"); put_text("c");
    put_text(8'(CODE_TAB));
    put_text(8'(CODE_LF));
    put_text("d");
    put_text(8'(CODE_CR));
    put_text("e");
    put_text(8'hC0); put_text(8'h80 | 8'(CODE_LF));
    put_text("f");
    drain_draws();
  endtask

  // Zero byte and string start dropping a partial sequence
  task automatic test_sequence_breaks();
    put_text(8'hE2); put_text(8'h00); put_text("g");
    put_text(8'hE2); put_text(8'h82); put_text("h", 1'b1);
    put_text(8'hF0); put_text(8'h9F); put_text(8'h00); put_text("i");
    drain_draws();
  endtask

  // Zero and all-ones registers, off-screen drops and cursor saturation
  task automatic test_register_extremes();
    write_reg(REG_ORIGIN_X, 0);
    write_reg(REG_ORIGIN_Y, 0);
    write_reg(REG_GLYPH_WIDTH, 0);
    write_reg(REG_GLYPH_HEIGHT, 0);
    write_reg(REG_GLYPH_COUNT, 0);
    write_reg(REG_SCREEN_WIDTH, 0);
    write_reg(REG_SCREEN_HEIGHT, 0);
    write_reg(REG_PEN_COLOR, 0);
    put_text("A", 1'b1); put_text("B");
    drain_draws();
    write_reg(REG_SCREEN_WIDTH, 32'h0000_FFFF);
    write_reg(REG_SCREEN_HEIGHT, 32'h0000_FFFF);
    put_text("C"); put_text(8'(CODE_LF)); put_text("C");
    drain_draws();
    write_reg(REG_ORIGIN_X, 32'h0000_FFF0);
    write_reg(REG_ORIGIN_Y, 32'h0000_FFFE);
    write_reg(REG_GLYPH_WIDTH, 32'h0000_003F);
    write_reg(REG_GLYPH_HEIGHT, 32'h0000_007F);
    write_reg(REG_GLYPH_COUNT, 32'h0000_FFFF);
    write_reg(REG_PEN_COLOR, 32'hFFFF_FFFF);
    put_text("D", 1'b1); put_text("E");
    put_text(8'(CODE_LF)); put_text("F");
    put_text("G", 1'b1); put_text(8'(CODE_CR));
    put_text(8'(CODE_TAB)); put_text("H");
    drain_draws();
  endtask

  task automatic test_random_text(input int unsigned idle_pct, input int unsigned stall_pct,
                                  input int unsigned n_words);
    int unsigned first;
    setup_random_font();
    send_idle_pct   = idle_pct;
    ready_stall_pct = stall_pct;
    first = text_words_sent;
    while (text_words_sent - first < n_words) send_random_char();
    drain_draws();
    send_idle_pct   = 0;
    ready_stall_pct = 0;
  endtask

  // Draw channel held off while text keeps coming, so the input backs up
  task automatic test_output_backpressure();
    int unsigned first;
    write_reg(REG_ORIGIN_X, 0);
    write_reg(REG_ORIGIN_Y, 0);
    write_reg(REG_GLYPH_WIDTH, 8);
    write_reg(REG_SCREEN_WIDTH, 32'h0000_FFFF);
    write_reg(REG_SCREEN_HEIGHT, 32'h0000_FFFF);
    hold_req = 1'b1;
    put_text("S", 1'b1);
    first = text_words_sent;
    while (text_words_sent - first < 60) put_text(8'($urandom_range(32, 126)));
    drain_draws();
  endtask

  initial begin
    reset_predictor();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_decode();
    test_cursor_controls();
    test_sequence_breaks();
    test_register_extremes();
    test_random_text(0, 0, 320);
    test_random_text(73, 0, 320);
    test_random_text(0, 73, 320);
    test_random_text(36, 36, 320);
    test_output_backpressure();

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
